// ----- design/mva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_pkg: shared types and constants for the MIDI voice allocator
// Opcodes, the command broadcast to the voice cells and the search carry
// that travels down the cell chain.
// ----------------------------------------------------------------------------
package mva_pkg;

   // event opcodes
   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_CH_OFF   = 2'd2;
   localparam logic [1:0] OP_TICK     = 2'd3;

   // field widths
   localparam int OP_W     = 2;
   localparam int NOTE_W   = 7;
   localparam int CH_W     = 4;
   localparam int MAP_W    = 3;   // channel bits per voice in the map
   localparam int MAP_VOX  = 8;   // voices covered by the map and masks
   localparam int CMAP_W   = MAP_W * MAP_VOX;
   localparam int STAMP_W  = 32;
   localparam int VIDX_W   = 4;   // voice index, covers up to 16 voices
   localparam int VOUT_W   = 3;
   localparam int DAC_W    = 12;

   // pitch code: floor(note * 273 / 4), saturated
   localparam int                DAC_PROD_W = 16;
   localparam logic [DAC_PROD_W-1:0] DAC_SCALE = 16'd273;
   localparam logic [NOTE_W-1:0] NOTE_SAT   = 7'd60;
   localparam logic [DAC_W-1:0]  DAC_MAX    = 12'd4095;

   // command seen by every cell
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [NOTE_W-1:0]  note;
      logic [CH_W-1:0]    ch;
      logic [STAMP_W-1:0] stamp;
      logic [VIDX_W-1:0]  pick;
      logic               accept;
      logic               apply;    // one-cycle update strobe
   } mva_cmd_type;

   // search carry passed cell to cell
   typedef struct packed {
      logic               mapped;
      logic               found;
      logic [VIDX_W-1:0]  free_idx;
      logic               have;
      logic [STAMP_W-1:0] oldest;
      logic [VIDX_W-1:0]  old_idx;
   } mva_carry_type;

endpackage

// ----- design/mva_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_cell: one voice of the allocator
// Holds note, gate, trigger and press stamp of one voice, folds its own
// state into the search carry and registers it toward the next cell.
// ----------------------------------------------------------------------------
module mva_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mva_pkg::mva_cmd_type          cmd,
   input  logic [mva_pkg::MAP_W-1:0]     chan_map,
   input  mva_pkg::mva_carry_type        carry_in,
   output mva_pkg::mva_carry_type        carry_out,
   output logic                          gate,
   output logic                          trig
);

   localparam logic [mva_pkg::VIDX_W-1:0] MY_IDX = mva_pkg::VIDX_W'(INDEX);

   logic [mva_pkg::NOTE_W-1:0]  note_ff, note_in;
   logic                        gate_ff, gate_in;
   logic                        trig_ff, trig_in;
   logic [mva_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   mva_pkg::mva_carry_type      carry_ff, carry_in_nx;
   logic                        match;
   logic [mva_pkg::STAMP_W-1:0] age;

   assign match = ({1'b0, chan_map} == cmd.ch);
   assign age   = cmd.stamp - stamp_ff;

   // search step: lowest free voice and oldest press on this channel
   always_comb begin
      carry_in_nx = carry_in;
      if (match) begin
         carry_in_nx.mapped = 1'b1;
         if (!carry_in.found && !gate_ff) begin
            carry_in_nx.found    = 1'b1;
            carry_in_nx.free_idx = MY_IDX;
         end
         if (!carry_in.have || (age > carry_in.oldest)) begin
            carry_in_nx.have    = 1'b1;
            carry_in_nx.oldest  = age;
            carry_in_nx.old_idx = MY_IDX;
         end
      end
   end

   // voice state update on the apply beat
   always_comb begin
      note_in  = note_ff;
      gate_in  = gate_ff;
      trig_in  = trig_ff;
      stamp_in = stamp_ff;
      if (cmd.apply) begin
         case (cmd.op)
            mva_pkg::OP_NOTE_ON: begin
               if (cmd.accept && (cmd.pick == MY_IDX)) begin
                  note_in  = cmd.note;
                  gate_in  = 1'b1;
                  trig_in  = 1'b1;
                  stamp_in = cmd.stamp;
               end
            end
            mva_pkg::OP_NOTE_OFF: begin
               if (match && (note_ff == cmd.note)) gate_in = 1'b0;
            end
            mva_pkg::OP_CH_OFF: begin
               if (match) begin
                  gate_in = 1'b0;
                  trig_in = 1'b0;
               end
            end
            mva_pkg::OP_TICK: begin
               trig_in = 1'b0;
            end
            default: begin
               trig_in = trig_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff  <= '0;
         gate_ff  <= 1'b0;
         trig_ff  <= 1'b0;
         stamp_ff <= '0;
         carry_ff <= '0;
      end else begin
         note_ff  <= note_in;
         gate_ff  <= gate_in;
         trig_ff  <= trig_in;
         stamp_ff <= stamp_in;
         carry_ff <= carry_in_nx;
      end
   end

   assign carry_out = carry_ff;
   assign gate      = gate_ff;
   assign trig      = trig_ff;

endmodule

// ----- design/midi_voice_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_voice_allocator: note event to gate/trigger/CV voice assignment
// Top level: command sequencer, channel map register and the voice chain.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive req_opcode/req_note/req_channel with start high; the beat
//    is taken on an edge where start is high and busy is low.
//  - Output: exactly one result per event, shown for one cycle with
//    rsp_strobe high. The receiver cannot hold it off.
//  - Config: csr_valid/csr_ready write the 24-bit channel map (3 bits per
//    voice); csr_ready is always high. Write only while busy is low.
//  - Sequence: note off, channel off and tick keep busy high through the
//    apply and result states, the strobe in the result state. Note on
//    first scans: the search carry ripples through one voice cell per
//    cycle, then come the decide, apply and result states. Next event may
//    start the cycle after the strobe.
//  - Reset: all voices idle, gates and triggers low, stamps zero, press
//    counter one, channel map zero (every voice on channel 0).
// ----------------------------------------------------------------------------
module midi_voice_allocator #(
   parameter int VOICES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // event channel
   input  logic                            start,
   output logic                            busy,
   input  logic [mva_pkg::OP_W-1:0]        req_opcode,
   input  logic [mva_pkg::NOTE_W-1:0]      req_note,
   input  logic [mva_pkg::CH_W-1:0]        req_channel,
   // result channel
   output logic                            rsp_strobe,
   output logic                            rsp_accepted,
   output logic [mva_pkg::VOUT_W-1:0]      rsp_voice,
   output logic                            rsp_dac_write,
   output logic [mva_pkg::DAC_W-1:0]       rsp_dac_value,
   output logic [mva_pkg::MAP_VOX-1:0]     rsp_gate_mask,
   output logic [mva_pkg::MAP_VOX-1:0]     rsp_trigger_mask,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mva_pkg::CMAP_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(VOICES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VOICES - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_APPLY  = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [mva_pkg::OP_W-1:0]       op_ff, op_in;
   logic [mva_pkg::NOTE_W-1:0]     note_ff, note_in;
   logic [mva_pkg::CH_W-1:0]       ch_ff, ch_in;
   logic [mva_pkg::VIDX_W-1:0]     pick_ff, pick_in;
   logic                           acc_ff, acc_in;
   logic [mva_pkg::DAC_W-1:0]      dac_ff, dac_in;
   logic [mva_pkg::STAMP_W-1:0]    stamp_ctr_ff, stamp_ctr_in;
   logic [mva_pkg::CMAP_W-1:0]     cmap_ff;

   mva_pkg::mva_cmd_type           cmd;
   mva_pkg::mva_carry_type         carry [0:VOICES];
   mva_pkg::mva_carry_type         result;
   logic [VOICES-1:0]              gate_vec, trig_vec;
   logic [mva_pkg::DAC_PROD_W-1:0] dac_prod;

   // channel map register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmap_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         cmap_ff <= csr_wdata;
      end
   end

   // command broadcast to the voice cells
   always_comb begin
      cmd.op     = op_ff;
      cmd.note   = note_ff;
      cmd.ch     = ch_ff;
      cmd.stamp  = stamp_ctr_ff;
      cmd.pick   = pick_ff;
      cmd.accept = acc_ff;
      cmd.apply  = (state_ff == ST_APPLY);
   end

   // voice chain
   assign carry[0] = '0;

   for (genvar g = 0; g < VOICES; g++) begin : g_voice
      mva_cell #(.INDEX(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chan_map  (cmap_ff[mva_pkg::MAP_W*(g % mva_pkg::MAP_VOX) +: mva_pkg::MAP_W]),
         .carry_in  (carry[g]),
         .carry_out (carry[g+1]),
         .gate      (gate_vec[g]),
         .trig      (trig_vec[g])
      );
   end

   assign result   = carry[VOICES];
   assign dac_prod = mva_pkg::DAC_PROD_W'(note_ff) * mva_pkg::DAC_SCALE;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      note_in      = note_ff;
      ch_in        = ch_ff;
      pick_in      = pick_ff;
      acc_in       = acc_ff;
      dac_in       = dac_ff;
      stamp_ctr_in = stamp_ctr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               note_in  = req_note;
               ch_in    = req_channel;
               pick_in  = '0;
               acc_in   = 1'b0;
               dac_in   = '0;
               cnt_in   = '0;
               state_in = (req_opcode == mva_pkg::OP_NOTE_ON) ? ST_SCAN : ST_APPLY;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            acc_in  = result.mapped;
            pick_in = result.found ? result.free_idx : result.old_idx;
            if (result.mapped) begin
               dac_in = (note_ff > mva_pkg::NOTE_SAT) ? mva_pkg::DAC_MAX
                                                      : dac_prod[13:2];
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if ((op_ff == mva_pkg::OP_NOTE_ON) && acc_ff) begin
               stamp_ctr_in = stamp_ctr_ff + mva_pkg::STAMP_W'(1);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         acc_ff       <= 1'b0;
         stamp_ctr_ff <= mva_pkg::STAMP_W'(1);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         stamp_ctr_ff <= stamp_ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      note_ff <= note_in;
      ch_ff   <= ch_in;
      pick_ff <= pick_in;
      dac_ff  <= dac_in;
   end

   // result beat
   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = (state_ff == ST_RESP);
   assign rsp_accepted  = acc_ff;
   assign rsp_dac_write = acc_ff;
   assign rsp_voice     = pick_ff[mva_pkg::VOUT_W-1:0];
   assign rsp_dac_value = dac_ff;

   always_comb begin
      rsp_gate_mask    = '0;
      rsp_trigger_mask = '0;
      for (int i = 0; i < mva_pkg::MAP_VOX; i++) begin
         if (i < VOICES) begin
            rsp_gate_mask[i]    = gate_vec[i];
            rsp_trigger_mask[i] = trig_vec[i];
         end
      end
   end

   // checks
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("event taken but sequencer not busy");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("sequencer did not return to idle after result");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_accepted) |-> (rsp_dac_value == '0 && rsp_voice == '0))
      else $error("rejected event carries voice or pitch");

endmodule
